/* rtl/hftd_pkg.sv */
// Package for the Huffman tree table decoder: field widths, table limits,
// mode and status codes and the controller state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hftd_pkg;

    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 8;
    localparam int BRANCH_W = 16;
    localparam int BYTE_W   = 8;
    localparam int SYMBOL_W = 8;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 24;
    localparam int ENTRY_W  = 2 * BRANCH_W;
    localparam int BIT_CNT_W = $clog2(BYTE_W);
    localparam int TABLE_DEPTH = 1 << INDEX_W;

    localparam int NODE_COUNT  = 255;
    localparam int BRANCH_BASE = 'h100;

    localparam logic [INDEX_W-1:0] ROOT_INDEX = INDEX_W'(254);
    localparam logic [BRANCH_W:0] BAD_LIMIT = (BRANCH_W + 1)'(BRANCH_BASE + NODE_COUNT);
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BYTE_W - 1);

    typedef logic [MODE_W-1:0] mode_t;
    localparam mode_t MODE_WRITE = 2'd0;
    localparam mode_t MODE_START = 2'd1;
    localparam mode_t MODE_BYTE  = 2'd2;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STAT_SYMBOL    = 2'd0;
    localparam status_t STAT_FINISH    = 2'd1;
    localparam status_t STAT_BAD_NODE  = 2'd2;
    localparam status_t STAT_UNDERFLOW = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_UNDER,
        ST_FLUSH
    } hftd_state_t;

endpackage

`default_nettype wire

/* rtl/hftd_if.sv */
// Channel interfaces of the Huffman tree table decoder: input items, results
// and the output length register. Depends on hftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hftd_in_if
    import hftd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [INDEX_W-1:0]  node_index;
    logic [BRANCH_W-1:0] zero_branch;
    logic [BRANCH_W-1:0] one_branch;
    logic [BYTE_W-1:0]   stream_byte;
    logic                last_byte;

    modport source (output valid, mode, node_index, zero_branch, one_branch,
                    stream_byte, last_byte, input ready);
    modport sink (input valid, mode, node_index, zero_branch, one_branch,
                  stream_byte, last_byte, output ready);
endinterface

interface hftd_out_if
    import hftd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, symbol, status, last, input ready);
    modport sink (input valid, symbol, status, last, output ready);
endinterface

interface hftd_cfg_if
    import hftd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [LENGTH_W-1:0] output_length;

    modport source (output valid, output_length, input ready);
    modport sink (input valid, output_length, output ready);
endinterface

`default_nettype wire

/* rtl/huffman_tree_table_decoder.sv */
// Huffman tree table decoder top level: node table memory, bit-serial tree
// walker and result register. Depends on hftd_pkg and the interfaces in hftd_if.
//
// Usage: the item channel carries one command per transfer. Mode 0 writes one
// node of the 256-entry table, mode 1 starts a decode at the root and clears
// the symbol count, mode 2 feeds one stream byte, mode 3 is ignored. The cfg
// channel sets the number of symbols to decode and is always ready.
// A stream byte is shifted out one bit per cycle while no held-back result
// waits on a stalled receiver; each bit is one read of the node table, and the
// registered table read closes the loop. Each result is held back one step so
// that the final result of a byte can carry last. A byte is walked bit by bit,
// then flushed, with a separate underflow result added first where needed; the
// next item is accepted only once the byte's flush is done, and a decode that
// ends early frees the input sooner. Table writes and start commands leave the
// decoder idle, so the input stays ready.
// While the receiver stalls, the walker holds its place and the input stays
// blocked. Reset idles the decoder, puts the walk at the root and the length at
// one; the table is not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_table_decoder
    import hftd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    hftd_in_if.sink   item,
    hftd_out_if.source result,
    hftd_cfg_if.sink  cfg
);

    logic [ENTRY_W-1:0] node_table [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    hftd_state_t state_reg, state_next;
    logic [INDEX_W-1:0]   walk_pos_reg, walk_pos_next;
    logic [LENGTH_W-1:0]  count_reg, count_next;
    logic                 active_reg, active_next;
    logic [LENGTH_W-1:0]  length_reg;
    logic [BYTE_W-1:0]    bits_reg, bits_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 final_reg, final_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [SYMBOL_W-1:0]  pend_sym_reg, pend_sym_next;
    status_t              pend_stat_reg, pend_stat_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0]  out_sym_reg, out_sym_next;
    status_t              out_stat_reg, out_stat_next;
    logic                 out_last_reg, out_last_next;

    logic                 in_xfer;
    logic                 out_free;
    logic [BRANCH_W-1:0]  branch;
    logic                 is_sym;
    logic                 is_bad;
    logic [LENGTH_W-1:0]  count_inc;
    logic                 res_valid;
    status_t              res_stat;
    logic [SYMBOL_W-1:0]  res_sym;

    assign item.ready = (state_reg == ST_IDLE);
    assign in_xfer = item.valid && item.ready;
    assign cfg.ready = 1'b1;
    assign out_free = !out_valid_reg || result.ready;

    assign result.valid = out_valid_reg;
    assign result.symbol = out_sym_reg;
    assign result.status = out_stat_reg;
    assign result.last = out_last_reg;

    assign branch = bits_reg[0] ? rd_data_reg[ENTRY_W-1:BRANCH_W]
                                : rd_data_reg[BRANCH_W-1:0];
    assign is_sym = (branch < BRANCH_W'(BRANCH_BASE));
    assign is_bad = !is_sym && ({1'b0, branch} >= BAD_LIMIT);
    assign count_inc = count_reg + LENGTH_W'(1);

    always_ff @(posedge clk)
    begin
        if (in_xfer && (mode_t'(item.mode) == MODE_WRITE))
        begin
            node_table[item.node_index] <= {item.one_branch, item.zero_branch};
        end
        rd_data_reg <= node_table[walk_pos_next];
    end

    always_comb
    begin
        state_next = state_reg;
        walk_pos_next = walk_pos_reg;
        count_next = count_reg;
        active_next = active_reg;
        bits_next = bits_reg;
        bit_cnt_next = bit_cnt_reg;
        final_next = final_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next = pend_sym_reg;
        pend_stat_next = pend_stat_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_sym_next = out_sym_reg;
        out_stat_next = out_stat_reg;
        out_last_next = out_last_reg;
        res_valid = 1'b0;
        res_stat = STAT_SYMBOL;
        res_sym = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (mode_t'(item.mode))
                        MODE_START:
                        begin
                            walk_pos_next = ROOT_INDEX;
                            count_next = '0;
                            active_next = 1'b1;
                        end
                        MODE_BYTE:
                        begin
                            if (active_reg)
                            begin
                                bits_next = item.stream_byte;
                                bit_cnt_next = '0;
                                final_next = item.last_byte;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (is_sym)
                    begin
                        count_next = count_inc;
                        walk_pos_next = ROOT_INDEX;
                        res_valid = 1'b1;
                        res_sym = branch[SYMBOL_W-1:0];
                        res_stat = (count_inc >= length_reg) ? STAT_FINISH : STAT_SYMBOL;
                    end
                    else if (is_bad)
                    begin
                        res_valid = 1'b1;
                        res_stat = STAT_BAD_NODE;
                    end
                    else
                    begin
                        walk_pos_next = branch[INDEX_W-1:0];
                    end

                    if (res_valid)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_sym_next = pend_sym_reg;
                            out_stat_next = pend_stat_reg;
                            out_last_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next = res_sym;
                        pend_stat_next = res_stat;
                    end

                    if (res_valid && (res_stat != STAT_SYMBOL))
                    begin
                        active_next = 1'b0;
                        state_next = ST_FLUSH;
                    end
                    else if (bit_cnt_reg == LAST_BIT)
                    begin
                        if (final_reg)
                        begin
                            active_next = 1'b0;
                            if (is_sym)
                            begin
                                pend_stat_next = STAT_UNDERFLOW;
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                state_next = ST_UNDER;
                            end
                        end
                        else
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        bits_next = bits_reg >> 1;
                        bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                    end
                end
            end
            ST_UNDER:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_sym_next = pend_sym_reg;
                        out_stat_next = pend_stat_reg;
                        out_last_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_sym_next = '0;
                    pend_stat_next = STAT_UNDERFLOW;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next = pend_sym_reg;
                    out_stat_next = pend_stat_reg;
                    out_last_next = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_pos_reg <= ROOT_INDEX;
            count_reg <= '0;
            active_reg <= 1'b0;
            length_reg <= LENGTH_W'(1);
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_pos_reg <= walk_pos_next;
            count_reg <= count_next;
            active_reg <= active_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                length_reg <= cfg.output_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        bit_cnt_reg <= bit_cnt_next;
        final_reg <= final_next;
        pend_sym_reg <= pend_sym_next;
        pend_stat_reg <= pend_stat_next;
        out_sym_reg <= out_sym_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    // A new item is taken only when no result of the previous byte is held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !pend_valid_reg)
        else $error("input ready while a result is still pending");

    // Any result that ends a decode is the final result of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != STAT_SYMBOL)) |-> result.last)
        else $error("terminating result without last");

    // The walker only runs for an active decode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> active_reg)
        else $error("tree walk while decode is idle");

    // Every byte walk starts at its first bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) && ($past(state_reg) == ST_IDLE)) |-> (bit_cnt_reg == '0))
        else $error("byte walk did not start at bit zero");

endmodule

`default_nettype wire

/* verif/huffman_tree_table_decoder_tb.sv */
// Self-checking testbench for huffman_tree_table_decoder: directed and random node table
// loads, decode starts and stream bytes, checked against an in-bench tree walker.
// Depends on hftd_pkg and the channel interfaces in hftd_if.
`timescale 1ns / 1ps

module huffman_tree_table_decoder_tb;
    import hftd_pkg::*;

    localparam mode_t MODE_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        mode_t               mode;
        logic [INDEX_W-1:0]  node_index;
        logic [BRANCH_W-1:0] zero_branch;
        logic [BRANCH_W-1:0] one_branch;
        logic [BYTE_W-1:0]   stream_byte;
        logic                last_byte;
    } stream_item_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        status_t             status;
        logic                last;
    } symbol_result_t;

    logic clk;
    logic rst_n;

    hftd_in_if  item_ch ();
    hftd_out_if res_ch ();
    hftd_cfg_if cfg_ch ();

    huffman_tree_table_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    stream_item_t   item_feed_q[$];
    symbol_result_t symbol_results_q[$];
    stream_item_t   next_item;
    bit             item_taken;

    logic [ENTRY_W-1:0]  tree_nodes [TABLE_DEPTH];
    logic [INDEX_W-1:0]  walk_at;
    logic [LENGTH_W-1:0] sym_count;
    logic [LENGTH_W-1:0] run_length;
    bit                  walking;

    bit gen_written [TABLE_DEPTH];
    int live_nodes[$];

    int send_idle_pct;
    int stall_pct;
    int hold_req_cnt;
    int hold_served;
    int hold_left;

    int cycles;
    int mismatches;
    int results_checked;
    int cfg_writes;
    int failures;
    int mode_seen [4];
    int status_seen [4];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void predict_symbols(input stream_item_t it);
        symbol_result_t res [9];
        int n;
        int b;
        bit eighth;
        logic [ENTRY_W-1:0] entry;
        logic [BRANCH_W-1:0] nxt;
        n = 0;
        eighth = 1'b0;
        if (it.mode == MODE_WRITE)
        begin
            tree_nodes[it.node_index] = {it.one_branch, it.zero_branch};
        end
        else if (it.mode == MODE_START)
        begin
            walk_at = ROOT_INDEX;
            sym_count = '0;
            walking = 1'b1;
        end
        else if (it.mode == MODE_BYTE && walking)
        begin
            for (b = 0; b < BYTE_W && walking; b++)
            begin
                entry = tree_nodes[walk_at];
                nxt = it.stream_byte[b] ? entry[ENTRY_W-1:BRANCH_W] : entry[BRANCH_W-1:0];
                if (nxt < BRANCH_BASE)
                begin
                    sym_count = sym_count + 1'b1;
                    res[n].symbol = nxt[SYMBOL_W-1:0];
                    res[n].last = 1'b0;
                    if (sym_count >= run_length)
                    begin
                        res[n].status = STAT_FINISH;
                        walking = 1'b0;
                    end
                    else
                    begin
                        res[n].status = STAT_SYMBOL;
                        if (b == BYTE_W - 1)
                            eighth = 1'b1;
                    end
                    n++;
                    walk_at = ROOT_INDEX;
                end
                else if (nxt - BRANCH_BASE >= NODE_COUNT)
                begin
                    res[n].symbol = '0;
                    res[n].status = STAT_BAD_NODE;
                    res[n].last = 1'b0;
                    n++;
                    walking = 1'b0;
                end
                else
                begin
                    walk_at = INDEX_W'(nxt - BRANCH_BASE);
                end
            end
            if (walking && it.last_byte)
            begin
                // A symbol on the eighth bit carries the underflow itself.
                if (eighth)
                begin
                    res[n-1].status = STAT_UNDERFLOW;
                end
                else
                begin
                    res[n].symbol = '0;
                    res[n].status = STAT_UNDERFLOW;
                    res[n].last = 1'b0;
                    n++;
                end
                walking = 1'b0;
            end
            if (n > 0)
                res[n-1].last = 1'b1;
            for (b = 0; b < n; b++)
                symbol_results_q.push_back(res[b]);
        end
    endfunction

    // Driver: offers the next pending item at the falling edge.
    always @(negedge clk)
    begin
        if (!item_ch.valid || item_taken)
        begin
            if (item_feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_item = item_feed_q.pop_front();
                item_ch.valid       <= 1'b1;
                item_ch.mode        <= next_item.mode;
                item_ch.node_index  <= next_item.node_index;
                item_ch.zero_branch <= next_item.zero_branch;
                item_ch.one_branch  <= next_item.one_branch;
                item_ch.stream_byte <= next_item.stream_byte;
                item_ch.last_byte   <= next_item.last_byte;
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (hold_served != hold_req_cnt)
        begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor: checks each result transfer and runs the prediction on each item transfer.
    always @(posedge clk)
    begin
        symbol_result_t got;
        symbol_result_t want;
        stream_item_t   seen;
        if (rst_n)
        begin
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("Timeout after %0d cycles with %0d results outstanding.",
                         cycles, symbol_results_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                if (res_ch.valid && res_ch.ready)
                begin
                    got.symbol = res_ch.symbol;
                    got.status = res_ch.status;
                    got.last = res_ch.last;
                    results_checked++;
                    status_seen[got.status]++;
                    if (symbol_results_q.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("Unexpected result: symbol %02h status %0d last %0d",
                                     got.symbol, got.status, got.last);
                    end
                    else
                    begin
                        want = symbol_results_q.pop_front();
                        if (got.symbol !== want.symbol || got.status !== want.status ||
                            got.last !== want.last)
                        begin
                            mismatches++;
                            if (mismatches <= REPORT_MAX)
                                $display({"Result %0d: expected symbol %02h status %0d last %0d,",
                                          " got symbol %02h status %0d last %0d"},
                                         results_checked, want.symbol, want.status,
                                         want.last, got.symbol, got.status, got.last);
                        end
                    end
                end
                if (cfg_ch.valid && cfg_ch.ready)
                begin
                    run_length = cfg_ch.output_length;
                    cfg_writes++;
                end
                if (item_ch.valid && item_ch.ready)
                begin
                    seen.mode = item_ch.mode;
                    seen.node_index = item_ch.node_index;
                    seen.zero_branch = item_ch.zero_branch;
                    seen.one_branch = item_ch.one_branch;
                    seen.stream_byte = item_ch.stream_byte;
                    seen.last_byte = item_ch.last_byte;
                    mode_seen[seen.mode]++;
                    predict_symbols(seen);
                    item_taken = 1'b1;
                end
            end
        end
    end

    task automatic push_item(input mode_t m, input logic [INDEX_W-1:0] idx,
                             input logic [BRANCH_W-1:0] zb, input logic [BRANCH_W-1:0] ob,
                             input logic [BYTE_W-1:0] sb, input logic lb);
        stream_item_t it;
        it.mode = m;
        it.node_index = idx;
        it.zero_branch = zb;
        it.one_branch = ob;
        it.stream_byte = sb;
        it.last_byte = lb;
        item_feed_q.push_back(it);
    endtask

    // Nodes below the node count become legal walk targets once written.
    task automatic push_node(input logic [INDEX_W-1:0] idx, input logic [BRANCH_W-1:0] zb,
                             input logic [BRANCH_W-1:0] ob);
        push_item(MODE_WRITE, idx, zb, ob, BYTE_W'($urandom), 1'($urandom));
        if (idx < NODE_COUNT && !gen_written[idx])
        begin
            gen_written[idx] = 1'b1;
            live_nodes.push_back(idx);
        end
    endtask

    task automatic push_start();
        push_item(MODE_START, INDEX_W'($urandom), BRANCH_W'($urandom), BRANCH_W'($urandom),
                  BYTE_W'($urandom), 1'($urandom));
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] sb, input logic lb);
        push_item(MODE_BYTE, INDEX_W'($urandom), BRANCH_W'($urandom), BRANCH_W'($urandom),
                  sb, lb);
    endtask

    // Branches only point at symbols, written nodes or out-of-range nodes.
    function automatic logic [BRANCH_W-1:0] pick_branch();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return BRANCH_W'($urandom_range(0, BRANCH_BASE - 1));
        else if (r < 92)
            return BRANCH_W'(BRANCH_BASE + live_nodes[$urandom_range(0, live_nodes.size() - 1)]);
        else
            return BRANCH_W'($urandom_range(BRANCH_BASE + NODE_COUNT, (1 << BRANCH_W) - 1));
    endfunction

    task automatic push_random_node();
        logic [INDEX_W-1:0] idx;
        logic [BRANCH_W-1:0] zb;
        logic [BRANCH_W-1:0] ob;
        idx = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
        zb = pick_branch();
        ob = pick_branch();
        push_node(idx, zb, ob);
    endtask

    task automatic random_phase(input int n_items);
        int made;
        int r;
        int nb;
        int k;
        made = 0;
        while (made < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                push_random_node();
                made++;
            end
            else if (r < 16)
            begin
                push_item(MODE_UNUSED, INDEX_W'($urandom), BRANCH_W'($urandom),
                          BRANCH_W'($urandom), BYTE_W'($urandom), 1'($urandom));
            end
            else if (r < 19)
            begin
                push_byte(BYTE_W'($urandom), 1'($urandom));
            end
            else
            begin
                push_start();
                nb = $urandom_range(1, 5);
                for (k = 0; k < nb; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        push_random_node();
                    push_byte(BYTE_W'($urandom), (k == nb - 1) && $urandom_range(0, 1));
                end
                made += 1 + nb;
            end
        end
    endtask

    task automatic drain_results();
        while (item_feed_q.size() != 0 || item_ch.valid || symbol_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_length(input logic [LENGTH_W-1:0] len);
        int start_cnt;
        start_cnt = cfg_writes;
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.output_length <= len;
        do
            @(negedge clk);
        while (cfg_writes == start_cnt);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.mode = MODE_WRITE;
        item_ch.node_index = '0;
        item_ch.zero_branch = '0;
        item_ch.one_branch = '0;
        item_ch.stream_byte = '0;
        item_ch.last_byte = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.output_length = '0;
        item_taken = 1'b0;
        walk_at = ROOT_INDEX;
        sym_count = '0;
        walking = 1'b0;
        run_length = LENGTH_W'(1);
        hold_req_cnt = 0;
        hold_served = 0;
        hold_left = 0;
        set_idling(0, 0);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Small fixed tree: 0 -> 'A', 10 -> FF, 110 then 1 -> 80, 1100 and 111 hit bad nodes.
        push_node(ROOT_INDEX, 16'h0041, 16'h0100);
        push_node(8'd0, 16'h00FF, 16'h0101);
        push_node(8'd1, 16'h0102, 16'hFFFF);
        push_node(8'd2, 16'h01FF, 16'h0080);
        push_node(8'd255, 16'hFFFF, 16'hFFFF);
        push_item(MODE_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_start();
        push_byte(8'h00, 1'b0);
        drain_results();
        set_length('0);
        push_start();
        push_byte(8'h00, 1'b0);
        push_start();
        push_byte(8'h07, 1'b0);
        drain_results();
        set_length({LENGTH_W{1'b1}});
        push_start();
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b1);
        push_start();
        push_byte(8'h00, 1'b1);
        push_start();
        push_byte(8'h0B, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h00, 1'b0);
        push_start();
        push_byte(8'h02, 1'b1);
        push_start();
        push_node(8'd0, 16'h00FF, 16'h0101);
        push_byte(8'hFF, 1'b1);
        drain_results();

        set_length(LENGTH_W'($urandom_range(2, 12)));
        random_phase(20);
        drain_results();

        // Long receiver hold-off while bytes keep coming.
        set_length({LENGTH_W{1'b1}});
        hold_req_cnt++;
        push_start();
        for (k = 0; k < 10; k++)
            push_byte(BYTE_W'($urandom), 1'b0);
        drain_results();

        set_idling(65, 0);
        random_phase(20);
        drain_results();

        set_idling(0, 65);
        set_length(LENGTH_W'(1));
        random_phase(20);
        drain_results();

        set_idling(15, 15);
        set_length(LENGTH_W'($urandom_range(3, 40)));
        random_phase(20);
        drain_results();

        failures = mismatches + symbol_results_q.size();
        $display("Items: %0d node writes, %0d starts, %0d bytes, %0d unused; %0d length writes.",
                 mode_seen[MODE_WRITE], mode_seen[MODE_START], mode_seen[MODE_BYTE],
                 mode_seen[MODE_UNUSED], cfg_writes);
        $display("Results: %0d checked (%0d symbol, %0d finish, %0d bad node, %0d underflow).",
                 results_checked, status_seen[STAT_SYMBOL], status_seen[STAT_FINISH],
                 status_seen[STAT_BAD_NODE], status_seen[STAT_UNDERFLOW]);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
